// File: hdl/tpb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the transformed point bounds block.
// No dependencies; used by the channel interfaces and the top level.
package tpb_pkg;

  localparam int unsigned AXES    = 3;
  localparam int unsigned COORD_W = 32;
  localparam int unsigned COEF_W  = 16;
  localparam int unsigned CFG_W   = 48;
  localparam int unsigned APB_W   = 64;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned PROD_W  = COORD_W + COEF_W;
  localparam int unsigned ACC_W   = PROD_W + 2;
  localparam int unsigned FRAC_SH = 14;
  localparam int unsigned QUO_W   = ACC_W - FRAC_SH;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic        [FUNC_W-1:0]  func_t;
  typedef logic        [CFG_W-1:0]   cfg_t;

  localparam func_t FUNC_VERTEX     = 2'd0;
  localparam func_t FUNC_VERTEX_END = 2'd1;
  localparam func_t FUNC_END        = 2'd2;
  localparam func_t FUNC_BAD        = 2'd3;

  localparam logic [1:0] REG_COEF_X = 2'd0;
  localparam logic [1:0] REG_COEF_Y = 2'd1;
  localparam logic [1:0] REG_COEF_Z = 2'd2;

  localparam cfg_t COEF_X_RST = 48'h0000_0000_4000;
  localparam cfg_t COEF_Y_RST = 48'h0000_4000_0000;
  localparam cfg_t COEF_Z_RST = 48'h4000_0000_0000;

  localparam coord_t COORD_MAX = 32'sh7FFF_FFFF;
  localparam coord_t COORD_MIN = 32'sh8000_0000;

  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(8192);

endpackage

// File: hdl/tpb_if.sv
`timescale 1ns / 1ps
// Valid/ready channels for vertex items in and box items out.
// Depends on tpb_pkg for field types.
interface tpb_vertex_if;
  logic                valid;
  logic                ready;
  tpb_pkg::func_t      func;
  tpb_pkg::coord_t     vertex_x;
  tpb_pkg::coord_t     vertex_y;
  tpb_pkg::coord_t     vertex_z;

  modport source (output valid, func, vertex_x, vertex_y, vertex_z, input ready);
  modport sink   (input valid, func, vertex_x, vertex_y, vertex_z, output ready);
endinterface

interface tpb_box_if;
  logic                valid;
  logic                ready;
  tpb_pkg::coord_t     min_x;
  tpb_pkg::coord_t     min_y;
  tpb_pkg::coord_t     min_z;
  tpb_pkg::coord_t     max_x;
  tpb_pkg::coord_t     max_y;
  tpb_pkg::coord_t     max_z;

  modport source (output valid, min_x, min_y, min_z, max_x, max_y, max_z, input ready);
  modport sink   (input valid, min_x, min_y, min_z, max_x, max_y, max_z, output ready);
endinterface

// File: hdl/transformed_point_bounds_top.sv
`timescale 1ns / 1ps
// Transformed point bounds: rotate vertices, track per-axis min/max box.
// Depends on tpb_pkg and the channel interfaces in tpb_if.sv.
//
// Usage:
//   src_i carries vertex items (func, vertex_x/y/z, signed Q16.16). func
//   selects plain vertex, vertex and end, end only, or bad object.
//   box_o carries one box item per vertex-and-end, end-only or bad-object item.
//   The APB port writes the three 48-bit coefficient rows at 0x00, 0x08,
//   0x10; write them only while the block is idle.
// Timing:
//   One item is accepted per cycle while the input is not stalled (see Stall).
//   A box appears on box_o after the item that ends it has passed the input register,
//   the product register (nine 32x16 multipliers) and the rounded-sum register, then the
//   min/max update that loads the output register.
// Reset:
//   Coefficients return to the identity matrix and the running box to the
//   inverted empty box; no item is held.
// Stall:
//   While box_o waits, vertex items keep flowing. Input stalls only when an
//   ending item reaches the last stage while a box still waits in the output register.
module transformed_point_bounds_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tpb_vertex_if.sink                    src_i,
  tpb_box_if.source                     box_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tpb_pkg::ADDR_W-1:0]    paddr,
  input  logic [tpb_pkg::APB_W-1:0]     pwdata,
  output logic [tpb_pkg::APB_W-1:0]     prdata,
  output logic                          pready
);

  localparam int unsigned N = tpb_pkg::AXES;

  tpb_pkg::cfg_t coef_q [N];

  logic            s0_v_q, s1_v_q, s2_v_q;
  tpb_pkg::func_t  s0_func_q, s1_func_q, s2_func_q;
  tpb_pkg::coord_t s0_vtx_q [N];

  logic signed [tpb_pkg::PROD_W-1:0] prod_d [N][N];
  logic signed [tpb_pkg::PROD_W-1:0] prod_q [N][N];

  tpb_pkg::coord_t t_d [N];
  tpb_pkg::coord_t t_q [N];

  tpb_pkg::coord_t lo_q [N];
  tpb_pkg::coord_t hi_q [N];
  tpb_pkg::coord_t lo_upd [N];
  tpb_pkg::coord_t hi_upd [N];
  tpb_pkg::coord_t box_lo_d [N];
  tpb_pkg::coord_t box_hi_d [N];
  tpb_pkg::coord_t box_lo_q [N];
  tpb_pkg::coord_t box_hi_q [N];

  logic out_v_q;
  logic s2_emits;
  logic s2_has_vtx;
  logic adv;
  logic cfg_wr;

  assign s2_emits   = (s2_func_q != tpb_pkg::FUNC_VERTEX);
  assign s2_has_vtx = (s2_func_q == tpb_pkg::FUNC_VERTEX) ||
                      (s2_func_q == tpb_pkg::FUNC_VERTEX_END);
  assign adv        = !(s2_v_q && s2_emits && out_v_q && !box_o.ready);

  assign src_i.ready = adv;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[4:3])
      tpb_pkg::REG_COEF_X: prdata = tpb_pkg::APB_W'(coef_q[0]);
      tpb_pkg::REG_COEF_Y: prdata = tpb_pkg::APB_W'(coef_q[1]);
      tpb_pkg::REG_COEF_Z: prdata = tpb_pkg::APB_W'(coef_q[2]);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[0] <= tpb_pkg::COEF_X_RST;
      coef_q[1] <= tpb_pkg::COEF_Y_RST;
      coef_q[2] <= tpb_pkg::COEF_Z_RST;
    end else if (cfg_wr) begin
      unique case (paddr[4:3])
        tpb_pkg::REG_COEF_X: coef_q[0] <= pwdata[tpb_pkg::CFG_W-1:0];
        tpb_pkg::REG_COEF_Y: coef_q[1] <= pwdata[tpb_pkg::CFG_W-1:0];
        tpb_pkg::REG_COEF_Z: coef_q[2] <= pwdata[tpb_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Products: input axis i, output axis j
  always_comb begin
    for (int i = 0; i < N; i++) begin
      for (int j = 0; j < N; j++) begin
        prod_d[i][j] =
          $signed({{tpb_pkg::COEF_W{s0_vtx_q[i][tpb_pkg::COORD_W-1]}}, s0_vtx_q[i]}) *
          $signed({{tpb_pkg::COORD_W{coef_q[i][tpb_pkg::COEF_W*j + tpb_pkg::COEF_W-1]}},
                   coef_q[i][tpb_pkg::COEF_W*j +: tpb_pkg::COEF_W]});
      end
    end
  end

  // Sum, round half up, saturate
  always_comb begin
    logic signed [tpb_pkg::ACC_W-1:0] acc;
    logic signed [tpb_pkg::QUO_W-1:0] quo;
    for (int j = 0; j < N; j++) begin
      acc = $signed({{2{prod_q[0][j][tpb_pkg::PROD_W-1]}}, prod_q[0][j]}) +
            $signed({{2{prod_q[1][j][tpb_pkg::PROD_W-1]}}, prod_q[1][j]}) +
            $signed({{2{prod_q[2][j][tpb_pkg::PROD_W-1]}}, prod_q[2][j]}) +
            tpb_pkg::ROUND_BIAS;
      quo = acc[tpb_pkg::ACC_W-1:tpb_pkg::FRAC_SH];
      if (quo > $signed(tpb_pkg::QUO_W'(tpb_pkg::COORD_MAX))) begin
        t_d[j] = tpb_pkg::COORD_MAX;
      end else if (quo < $signed({{(tpb_pkg::QUO_W-tpb_pkg::COORD_W){1'b1}},
                                  tpb_pkg::COORD_MIN})) begin
        t_d[j] = tpb_pkg::COORD_MIN;
      end else begin
        t_d[j] = quo[tpb_pkg::COORD_W-1:0];
      end
    end
  end

  // Min/max update and box selection
  always_comb begin
    for (int j = 0; j < N; j++) begin
      lo_upd[j] = (s2_has_vtx && (t_q[j] < lo_q[j])) ? t_q[j] : lo_q[j];
      hi_upd[j] = (s2_has_vtx && (t_q[j] > hi_q[j])) ? t_q[j] : hi_q[j];
      if (s2_func_q == tpb_pkg::FUNC_BAD) begin
        box_lo_d[j] = tpb_pkg::COORD_MIN;
        box_hi_d[j] = tpb_pkg::COORD_MAX;
      end else begin
        box_lo_d[j] = lo_upd[j];
        box_hi_d[j] = hi_upd[j];
      end
    end
  end

  // Pipeline control and running box
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q  <= 1'b0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      for (int j = 0; j < N; j++) begin
        lo_q[j] <= tpb_pkg::COORD_MAX;
        hi_q[j] <= tpb_pkg::COORD_MIN;
      end
    end else begin
      if (adv && s2_v_q && s2_emits) begin
        out_v_q <= 1'b1;
      end else if (out_v_q && box_o.ready) begin
        out_v_q <= 1'b0;
      end
      if (adv) begin
        s0_v_q <= src_i.valid;
        s1_v_q <= s0_v_q;
        s2_v_q <= s1_v_q;
        if (s2_v_q) begin
          if (s2_emits) begin
            for (int j = 0; j < N; j++) begin
              lo_q[j] <= tpb_pkg::COORD_MAX;
              hi_q[j] <= tpb_pkg::COORD_MIN;
            end
          end else begin
            for (int j = 0; j < N; j++) begin
              lo_q[j] <= lo_upd[j];
              hi_q[j] <= hi_upd[j];
            end
          end
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_func_q   <= src_i.func;
      s0_vtx_q[0] <= src_i.vertex_x;
      s0_vtx_q[1] <= src_i.vertex_y;
      s0_vtx_q[2] <= src_i.vertex_z;
      s1_func_q   <= s0_func_q;
      s2_func_q   <= s1_func_q;
      prod_q      <= prod_d;
      t_q         <= t_d;
      if (s2_v_q && s2_emits) begin
        box_lo_q <= box_lo_d;
        box_hi_q <= box_hi_d;
      end
    end
  end

  assign box_o.valid = out_v_q;
  assign box_o.min_x = box_lo_q[0];
  assign box_o.min_y = box_lo_q[1];
  assign box_o.min_z = box_lo_q[2];
  assign box_o.max_x = box_hi_q[0];
  assign box_o.max_y = box_hi_q[1];
  assign box_o.max_z = box_hi_q[2];

endmodule

// File: tb/tpb_bounds_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the transformed point bounds block: snoops the vertex and box
// channels and the APB writes, predicts each box and compares. Needs tpb_pkg, tpb_if.sv.
module tpb_bounds_checker
  import tpb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  tpb_vertex_if             src_i,
  tpb_box_if                box_i,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [APB_W-1:0]  pwdata,
  output int                fail_count_o,
  output int                pending_o,
  output int                boxes_o
);

  typedef struct {
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
  } box_t;

  cfg_t   coef_row [AXES];
  coord_t low_run  [AXES];
  coord_t high_run [AXES];
  box_t   boxes_due [$];

  function automatic longint coef_at(cfg_t row, int axis);
    logic signed [COEF_W-1:0] c;
    c = row[COEF_W*axis +: COEF_W];
    return longint'(c);
  endfunction

  function automatic coord_t rotate_axis(coord_t vx, coord_t vy, coord_t vz, int axis);
    longint acc;
    longint q;
    acc = longint'(vx) * coef_at(coef_row[0], axis)
        + longint'(vy) * coef_at(coef_row[1], axis)
        + longint'(vz) * coef_at(coef_row[2], axis);
    q = (acc + 64'sd8192) >>> FRAC_SH;
    if (q > longint'(COORD_MAX)) return COORD_MAX;
    if (q < longint'(COORD_MIN)) return COORD_MIN;
    return coord_t'(q);
  endfunction

  task automatic clear_run();
    for (int a = 0; a < AXES; a++) begin
      low_run[a]  = COORD_MAX;
      high_run[a] = COORD_MIN;
    end
  endtask

  task automatic absorb_vertex(coord_t vx, coord_t vy, coord_t vz);
    coord_t t;
    for (int a = 0; a < AXES; a++) begin
      t = rotate_axis(vx, vy, vz, a);
      if (t < low_run[a]) low_run[a] = t;
      if (t > high_run[a]) high_run[a] = t;
    end
  endtask

  task automatic close_set(bit widest);
    box_t b;
    if (widest) begin
      b = '{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX};
    end else begin
      b = '{low_run[0], low_run[1], low_run[2], high_run[0], high_run[1], high_run[2]};
    end
    boxes_due.push_back(b);
    clear_run();
  endtask

  task automatic compare_field(string tag, coord_t want, coord_t got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, tag, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      coef_row[0] = COEF_X_RST;
      coef_row[1] = COEF_Y_RST;
      coef_row[2] = COEF_Z_RST;
      clear_run();
      boxes_due.delete();
      fail_count_o = 0;
      boxes_o      = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2:0] == 3'b000) begin
        case (paddr[4:3])
          REG_COEF_X: coef_row[0] = pwdata[CFG_W-1:0];
          REG_COEF_Y: coef_row[1] = pwdata[CFG_W-1:0];
          REG_COEF_Z: coef_row[2] = pwdata[CFG_W-1:0];
          default: ;
        endcase
      end
      if (box_i.valid && box_i.ready) begin
        boxes_o++;
        if (boxes_due.size() == 0) begin
          $display("%0t ns: box with none expected, got min %0d %0d %0d max %0d %0d %0d",
                   $time, box_i.min_x, box_i.min_y, box_i.min_z,
                   box_i.max_x, box_i.max_y, box_i.max_z);
          fail_count_o++;
        end else begin
          box_t want;
          want = boxes_due.pop_front();
          compare_field("min_x", want.min_x, box_i.min_x);
          compare_field("min_y", want.min_y, box_i.min_y);
          compare_field("min_z", want.min_z, box_i.min_z);
          compare_field("max_x", want.max_x, box_i.max_x);
          compare_field("max_y", want.max_y, box_i.max_y);
          compare_field("max_z", want.max_z, box_i.max_z);
        end
      end
      if (src_i.valid && src_i.ready) begin
        case (src_i.func)
          FUNC_VERTEX: absorb_vertex(src_i.vertex_x, src_i.vertex_y, src_i.vertex_z);
          FUNC_VERTEX_END: begin
            absorb_vertex(src_i.vertex_x, src_i.vertex_y, src_i.vertex_z);
            close_set(1'b0);
          end
          FUNC_END: close_set(1'b0);
          FUNC_BAD: close_set(1'b1);
          default: ;
        endcase
      end
    end
    pending_o = boxes_due.size();
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Top of the transformed point bounds testbench: clock, reset, vertex stimulus,
// APB coefficient writes and the verdict. Needs tpb_pkg, tpb_if.sv, the DUT and tpb_bounds_checker.
module testbench;
  import tpb_pkg::*;

  localparam logic [1:0] REG_SPARE   = 2'd3;
  localparam int         LATENCY_PAD = 8;
  localparam int         PHASE_ITEMS = 80;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [APB_W-1:0]  pwdata;
  logic [APB_W-1:0]  prdata;
  logic              pready;

  int fail_count;
  int pending;
  int boxes_seen;
  int items_sent;
  int settings_used;
  int gap_pct;
  int stall_pct;

  tpb_vertex_if src ();
  tpb_box_if    box ();

  transformed_point_bounds_top uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .src_i   (src),
    .box_o   (box),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tpb_bounds_checker bounds_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .src_i        (src),
    .box_i        (box),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .boxes_o      (boxes_seen)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  always @(negedge clk_i) begin
    box.ready = ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #2_000_000;
    $display("** transformed_point_bounds_top: FAILED **");
    $finish;
  end

  function automatic coord_t pick_coord();
    case ($urandom_range(9))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2: return '0;
      3, 4, 5: return coord_t'(int'($urandom_range(1 << 20)) - (1 << 19));
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic cfg_t pick_row();
    return cfg_t'({$urandom, $urandom});
  endfunction

  task automatic send_item(func_t f, coord_t vx, coord_t vy, coord_t vz);
    while ($urandom_range(99) < gap_pct) begin
      src.valid = 1'b0;
      @(negedge clk_i);
    end
    src.valid    = 1'b1;
    src.func     = f;
    src.vertex_x = vx;
    src.vertex_y = vy;
    src.vertex_z = vz;
    do @(posedge clk_i); while (!src.ready);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic send_vertex(func_t f);
    send_item(f, pick_coord(), pick_coord(), pick_coord());
  endtask

  // drop valid and wait for every box, then let the pipeline empty
  task automatic drain_boxes();
    src.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (LATENCY_PAD) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [APB_W-1:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 3'b000};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic load_matrix(cfg_t cx, cfg_t cy, cfg_t cz);
    drain_boxes();
    write_reg(REG_COEF_X, APB_W'(cx));
    write_reg(REG_COEF_Y, APB_W'(cy));
    write_reg(REG_COEF_Z, APB_W'(cz));
    settings_used++;
  endtask

  task automatic send_set();
    int r;
    int n;
    r = $urandom_range(99);
    if (r < 8) begin
      send_vertex(FUNC_BAD);
    end else if (r < 14) begin
      send_vertex(FUNC_END);
    end else begin
      n = $urandom_range(6);
      repeat (n) send_vertex(($urandom_range(29) == 0) ? FUNC_BAD : FUNC_VERTEX);
      if ($urandom_range(1)) begin
        send_vertex(FUNC_VERTEX_END);
      end else begin
        send_vertex(FUNC_VERTEX);
        send_vertex(FUNC_END);
      end
    end
    if ($urandom_range(19) == 0) drain_boxes();
  endtask

  task automatic run_directed();
    send_vertex(FUNC_END);
    send_vertex(FUNC_BAD);
    send_item(FUNC_VERTEX, COORD_MAX, COORD_MIN, '0);
    send_item(FUNC_VERTEX, COORD_MIN, COORD_MAX, -32'sd1);
    send_vertex(FUNC_END);
    send_item(FUNC_VERTEX_END, 32'sd1, -32'sd1, coord_t'(32'h5555_5555));
    send_item(FUNC_VERTEX, coord_t'(32'hAAAA_AAAA), 32'sd7, -32'sd7);
    send_vertex(FUNC_BAD);
    send_vertex(FUNC_END);
    send_vertex(FUNC_VERTEX);
    send_vertex(FUNC_VERTEX_END);

    drain_boxes();
    write_reg(REG_SPARE, {$urandom, $urandom});
    load_matrix(48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF);
    send_item(FUNC_VERTEX, COORD_MAX, COORD_MAX, COORD_MAX);
    send_item(FUNC_VERTEX, COORD_MIN, COORD_MIN, COORD_MIN);
    send_item(FUNC_VERTEX_END, 32'sd1, -32'sd1, 32'sd1);

    load_matrix(48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000);
    send_item(FUNC_VERTEX, COORD_MAX, COORD_MAX, COORD_MAX);
    send_item(FUNC_VERTEX, COORD_MIN, COORD_MIN, COORD_MIN);
    send_vertex(FUNC_END);

    // half-unit coefficients put results exactly on the rounding boundary
    load_matrix(48'h2000_2000_2000, '0, '0);
    send_item(FUNC_VERTEX, 32'sd1, 32'sd5, 32'sd5);
    send_item(FUNC_VERTEX, -32'sd1, 32'sd5, 32'sd5);
    send_item(FUNC_VERTEX, -32'sd3, 32'sd5, 32'sd5);
    send_vertex(FUNC_END);
  endtask

  initial begin
    int phase_end;
    rst_ni        = 1'b0;
    src.valid     = 1'b0;
    src.func      = FUNC_VERTEX;
    src.vertex_x  = '0;
    src.vertex_y  = '0;
    src.vertex_z  = '0;
    box.ready     = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    gap_pct       = 0;
    stall_pct     = 0;
    items_sent    = 0;
    settings_used = 1;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    run_directed();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: load_matrix(COEF_X_RST, COEF_Y_RST, COEF_Z_RST);
        2: load_matrix(48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF);
        4: load_matrix(48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000);
        5: load_matrix('0, '0, '0);
        6: load_matrix('1, '1, '1);
        default: load_matrix(pick_row(), pick_row(), pick_row());
      endcase
      case (phase % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 49; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 49; end
        default: begin gap_pct = 25; stall_pct = 25; end
      endcase
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) send_set();
    end

    drain_boxes();
    $display("Covered %0d vertex items over %0d coefficient settings and four idle patterns;",
             items_sent, settings_used);
    $display("%0d boxes compared, %0d mismatches.", boxes_seen, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("** transformed_point_bounds_top: PASSED **");
    end else begin
      $display("** transformed_point_bounds_top: FAILED **");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/tpb_pkg.sv
hdl/tpb_if.sv
hdl/transformed_point_bounds_top.sv
tb/tpb_bounds_checker.sv
tb/testbench.sv
